// ===== hw/rtl/cfir_pkg.sv =====
package cfir_pkg;

  // Fixed widths of the sample, coefficient and result words
  localparam int SAMP_W   = 16;
  localparam int COEF_W   = 32;
  localparam int MUL_W    = 2 * SAMP_W;      // one real product
  localparam int PROD_W   = MUL_W + 1;       // complex product part
  localparam int SUM1_W   = PROD_W + 1;
  localparam int SUM2_W   = PROD_W + 2;
  localparam int OUT_W    = 36;
  localparam int MAX_TAPS = 8;
  localparam int REG_CNT  = 8;
  localparam int REG_IDX_W = 3;
  localparam int ADDR_W   = REG_IDX_W + 2;

  typedef struct packed {
    logic signed [SAMP_W-1:0] im;
    logic signed [SAMP_W-1:0] re;
  } sample_t;

  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [OUT_W-1:0]  acc_t;

  // Per-transfer control fanned out to every cell
  typedef struct packed {
    logic shift;   // take neighbour's sample
    logic clear;   // zero the sample instead (block start)
    logic load;    // register the product of the held sample
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/cfir_cell.sv =====
module cfir_cell (
  input  logic                           clk,
  input  logic                           rst_n,
  input  cfir_pkg::cell_ctrl_t           ctrl,
  input  cfir_pkg::sample_t              samp_i,
  input  logic [cfir_pkg::COEF_W-1:0]    coef_i,
  output cfir_pkg::sample_t              samp_o,
  output cfir_pkg::prod_t                prod_re_o,
  output cfir_pkg::prod_t                prod_im_o
);
  import cfir_pkg::*;

  sample_t                   samp_r;
  prod_t                     prod_re_r;
  prod_t                     prod_im_r;
  logic signed [SAMP_W-1:0]  c_re;
  logic signed [SAMP_W-1:0]  c_im;
  logic signed [MUL_W-1:0]   m_rr;
  logic signed [MUL_W-1:0]   m_ii;
  logic signed [MUL_W-1:0]   m_ri;
  logic signed [MUL_W-1:0]   m_ir;
  prod_t                     prod_re_nxt;
  prod_t                     prod_im_nxt;

  // coefficient: real in upper half, imaginary in lower half
  assign c_re = coef_i[COEF_W-1:SAMP_W];
  assign c_im = coef_i[SAMP_W-1:0];

  assign m_rr = MUL_W'(c_re) * MUL_W'(samp_r.re);
  assign m_ii = MUL_W'(c_im) * MUL_W'(samp_r.im);
  assign m_ri = MUL_W'(c_re) * MUL_W'(samp_r.im);
  assign m_ir = MUL_W'(c_im) * MUL_W'(samp_r.re);

  always_comb begin
    prod_re_nxt = PROD_W'(m_rr) - PROD_W'(m_ii);
    prod_im_nxt = PROD_W'(m_ri) + PROD_W'(m_ir);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      samp_r <= '0;
    end else if (ctrl.shift) begin
      samp_r <= ctrl.clear ? '0 : samp_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      prod_re_r <= prod_re_nxt;
      prod_im_r <= prod_im_nxt;
    end
  end

  assign samp_o    = samp_r;
  assign prod_re_o = prod_re_r;
  assign prod_im_o = prod_im_r;

endmodule

// ===== hw/rtl/cfir_sum.sv =====
module cfir_sum (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  cfir_pkg::prod_t       prod_re [cfir_pkg::MAX_TAPS],
  input  cfir_pkg::prod_t       prod_im [cfir_pkg::MAX_TAPS],
  output logic                  out_valid,
  input  logic                  out_ready,
  output cfir_pkg::acc_t        sum_re,
  output cfir_pkg::acc_t        sum_im
);
  import cfir_pkg::*;

  logic signed [SUM1_W-1:0] l1_re_r [MAX_TAPS/2];
  logic signed [SUM1_W-1:0] l1_im_r [MAX_TAPS/2];
  logic signed [SUM2_W-1:0] l2_re_r [MAX_TAPS/4];
  logic signed [SUM2_W-1:0] l2_im_r [MAX_TAPS/4];
  acc_t                     o_re_r;
  acc_t                     o_im_r;
  logic                     l1_v_r;
  logic                     l2_v_r;
  logic                     o_v_r;
  logic                     adv_o;
  logic                     adv_l2;
  logic                     adv_l1;

  // each level loads when empty or when the next one moves
  assign adv_o  = !o_v_r  || out_ready;
  assign adv_l2 = !l2_v_r || adv_o;
  assign adv_l1 = !l1_v_r || adv_l2;
  assign in_ready = adv_l1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l1_v_r <= 1'b0;
      l2_v_r <= 1'b0;
      o_v_r  <= 1'b0;
    end else begin
      if (adv_l1) l1_v_r <= in_valid;
      if (adv_l2) l2_v_r <= l1_v_r;
      if (adv_o)  o_v_r  <= l2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_l1) begin
      for (int i = 0; i < MAX_TAPS/2; i++) begin
        l1_re_r[i] <= SUM1_W'(prod_re[2*i]) + SUM1_W'(prod_re[2*i+1]);
        l1_im_r[i] <= SUM1_W'(prod_im[2*i]) + SUM1_W'(prod_im[2*i+1]);
      end
    end
    if (adv_l2) begin
      for (int i = 0; i < MAX_TAPS/4; i++) begin
        l2_re_r[i] <= SUM2_W'(l1_re_r[2*i]) + SUM2_W'(l1_re_r[2*i+1]);
        l2_im_r[i] <= SUM2_W'(l1_im_r[2*i]) + SUM2_W'(l1_im_r[2*i+1]);
      end
    end
    if (adv_o) begin
      o_re_r <= OUT_W'(l2_re_r[0]) + OUT_W'(l2_re_r[1]);
      o_im_r <= OUT_W'(l2_im_r[0]) + OUT_W'(l2_im_r[1]);
    end
  end

  assign out_valid = o_v_r;
  assign sum_re    = o_re_r;
  assign sum_im    = o_im_r;

endmodule

// ===== hw/rtl/complex_fir_filter.sv =====
// Complex FIR filter, direct form, for transmit pulse shaping.
// Input stream: in_tdata carries one CS16 sample (Q1.15 re/im), in_tuser
//   the block-start flag that zeroes the delay line before this sample.
// Output stream: out_tdata carries the full-precision complex sum over
//   NUM_TAPS taps (36-bit re/im, Q6.30 scale); no rounding or saturation.
// APB port: tap k coefficient at byte address 4*k (re in bits 31:16, im in
//   15:0); write only while the stream is idle. pready is tied high.
// Throughput: one sample per clock while out_tready is high; a row of cells,
//   one per tap, each holds a delayed sample and its own complex multiplier.
// Pipeline: a result goes through the cell shift, product register, two
//   adder levels and output register.
// Stall: every stage holds while the one after it is full and stalled;
//   in_tready stays high while any stage still has a bubble, so up to
//   five samples are held in flight while out_tready stays low.
// Reset: coefficients and delay line cleared to zero, pipeline empty.
module complex_fir_filter #(
  parameter int NUM_TAPS = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // in_tdata: sample_re [15:0], sample_im [31:16]
  input  logic [31:0]                        in_tdata,
  // in_tuser: block_start
  input  logic                               in_tuser,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // out_tdata: out_re [35:0], out_im [71:36]
  output logic [71:0]                        out_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [cfir_pkg::ADDR_W-1:0]        paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import cfir_pkg::*;

  logic [COEF_W-1:0]   coef_r [REG_CNT];
  logic [REG_IDX_W-1:0] reg_idx;
  logic                cfg_wr;

  sample_t             cur_samp;
  sample_t             cell_samp [NUM_TAPS];
  prod_t               cell_re   [NUM_TAPS];
  prod_t               cell_im   [NUM_TAPS];
  prod_t               tree_re   [MAX_TAPS];
  prod_t               tree_im   [MAX_TAPS];
  acc_t                sum_re;
  acc_t                sum_im;

  logic                v1_r;      // cells hold a window not yet multiplied
  logic                v2_r;      // cell products valid
  logic                adv1;
  logic                adv2;
  logic                sum_rdy;
  logic                in_xfer;
  cell_ctrl_t          ctrl_head;
  cell_ctrl_t          ctrl_tail;

  // ---------------- configuration ----------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign prdata  = coef_r[reg_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < REG_CNT; i++) coef_r[i] <= '0;
    end else if (cfg_wr) begin
      coef_r[reg_idx] <= pwdata;
    end
  end

  // ---------------- pipeline control ----------------
  assign adv2      = !v2_r || sum_rdy;
  assign adv1      = !v1_r || adv2;
  assign in_tready = adv1;
  assign in_xfer   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_tvalid;
      if (adv2) v2_r <= v1_r;
    end
  end

  assign cur_samp.re = in_tdata[15:0];
  assign cur_samp.im = in_tdata[31:16];

  // head cell always takes the new sample; the rest clear on block start
  assign ctrl_head = '{shift: in_xfer, clear: 1'b0, load: adv2};
  assign ctrl_tail = '{shift: in_xfer, clear: in_tuser, load: adv2};

  // ---------------- cell row ----------------
  for (genvar k = 0; k < NUM_TAPS; k++) begin : g_cell
    if (k == 0) begin : g_head
      cfir_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl_head),
        .samp_i    (cur_samp),
        .coef_i    (coef_r[k]),
        .samp_o    (cell_samp[k]),
        .prod_re_o (cell_re[k]),
        .prod_im_o (cell_im[k])
      );
    end else begin : g_tail
      cfir_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl_tail),
        .samp_i    (cell_samp[k-1]),
        .coef_i    (coef_r[k]),
        .samp_o    (cell_samp[k]),
        .prod_re_o (cell_re[k]),
        .prod_im_o (cell_im[k])
      );
    end
  end

  // pad the adder tree with zero for absent taps
  always_comb begin
    for (int k = 0; k < MAX_TAPS; k++) begin
      tree_re[k] = '0;
      tree_im[k] = '0;
    end
    for (int k = 0; k < NUM_TAPS; k++) begin
      tree_re[k] = cell_re[k];
      tree_im[k] = cell_im[k];
    end
  end

  cfir_sum u_sum (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v2_r),
    .in_ready  (sum_rdy),
    .prod_re   (tree_re),
    .prod_im   (tree_im),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .sum_re    (sum_re),
    .sum_im    (sum_im)
  );

  assign out_tdata = {sum_im, sum_re};

  // ---------------- assertions ----------------
  // a transfer always leaves a window waiting in the cells
  a_xfer_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> v1_r)
    else $error("accepted sample lost before multiply stage");

  // input back-pressure only when both front stages are full and blocked
  a_bp_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (v1_r && v2_r && !sum_rdy))
    else $error("input stalled with a free stage");

  // block start leaves only the new sample in the delay line; the last cell is checked
  if (NUM_TAPS > 1) begin : g_chk_clear
    a_blk_clear: assert property (@(posedge clk) disable iff (!rst_n)
      (in_xfer && in_tuser) |=> (cell_samp[NUM_TAPS-1] == '0))
      else $error("delay line not cleared on block start");
  end

endmodule

// ===== tb/fir_result_checker.sv =====
// Watches the sample, result and APB channels of the complex FIR filter.
// Keeps its own copy of the tap coefficients and delay line, predicts one
// complex sum per accepted sample, and compares results in order.
module fir_result_checker #(
  parameter int NUM_TAPS = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [31:0]                 in_tdata,
  input  logic                        in_tuser,
  input  logic                        in_tvalid,
  input  logic                        in_tready,
  input  logic [71:0]                 out_tdata,
  input  logic                        out_tvalid,
  input  logic                        out_tready,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cfir_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  input  logic [31:0]                 prdata,
  input  logic                        pready,
  output int                          fail_count,
  output int                          pending,
  output int                          results_checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import cfir_pkg::*;

  localparam int DELAY_DEPTH = MAX_TAPS - 1;
  localparam int MAX_PRINTS  = 40;

  typedef struct {
    logic [OUT_W-1:0] re;
    logic [OUT_W-1:0] im;
  } fir_result_t;

  logic [COEF_W-1:0] tap_coef [REG_CNT];
  sample_t           delay_line [DELAY_DEPTH];
  fir_result_t       expected_sums [$];
  fir_result_t       want;
  int                errors = 0;
  int                n_checked = 0;

  task automatic report_mismatch(input string what, input logic [71:0] got,
                                 input logic [71:0] exp_val);
    if (errors < MAX_PRINTS)
      $display("[%0t] mismatch on %s: got %0h, want %0h", $realtime, what, got, exp_val);
    errors++;
  endtask

  // One step of the direct-form filter: clear on block start, sum the
  // complex products, then push the current sample into the delay line.
  function automatic fir_result_t filter_step(input sample_t cur, input logic restart);
    fir_result_t res;
    sample_t     s;
    longint      acc_re;
    longint      acc_im;
    longint      cr;
    longint      ci;
    longint      sr;
    longint      si;
    if (restart)
      foreach (delay_line[k]) delay_line[k] = '0;
    acc_re = 0;
    acc_im = 0;
    for (int k = 0; k < NUM_TAPS; k++) begin
      s  = (k == 0) ? cur : delay_line[k-1];
      cr = longint'($signed(tap_coef[k][31:16]));
      ci = longint'($signed(tap_coef[k][15:0]));
      sr = longint'(s.re);
      si = longint'(s.im);
      acc_re += cr * sr - ci * si;
      acc_im += cr * si + ci * sr;
    end
    for (int k = DELAY_DEPTH - 1; k > 0; k--)
      delay_line[k] = delay_line[k-1];
    delay_line[0] = cur;
    res.re = acc_re[OUT_W-1:0];
    res.im = acc_im[OUT_W-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (tap_coef[i]) tap_coef[i] = '0;
      foreach (delay_line[i]) delay_line[i] = '0;
      expected_sums.delete();
    end else begin
      if (psel && penable && pready) begin
        if (pwrite)
          tap_coef[paddr[ADDR_W-1:2]] = pwdata;
        else if (prdata !== tap_coef[paddr[ADDR_W-1:2]])
          report_mismatch("coefficient readback", 72'(prdata),
                          72'(tap_coef[paddr[ADDR_W-1:2]]));
      end

      if (out_tvalid && out_tready) begin
        n_checked++;
        if (expected_sums.size() == 0) begin
          report_mismatch("result with no sample pending", out_tdata, '0);
        end else begin
          want = expected_sums.pop_front();
          if (out_tdata[OUT_W-1:0] !== want.re)
            report_mismatch("out_re", 72'(out_tdata[OUT_W-1:0]), 72'(want.re));
          if (out_tdata[2*OUT_W-1:OUT_W] !== want.im)
            report_mismatch("out_im", 72'(out_tdata[2*OUT_W-1:OUT_W]), 72'(want.im));
        end
      end

      if (in_tvalid && in_tready)
        expected_sums.push_back(filter_step(sample_t'(in_tdata), in_tuser));
    end
    fail_count      <= errors;
    pending         <= expected_sums.size();
    results_checked <= n_checked;
  end

endmodule

// ===== tb/tb.sv =====
// Top of the filter regression: clock, reset, sample stimulus, APB
// coefficient loads, result back-pressure, watchdog and the verdict.
// All prediction and comparison lives in fir_result_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cfir_pkg::*;

  localparam int TAPS           = 8;
  localparam int TAP_STRIDE     = 4;     // byte distance between tap registers
  localparam int PHASE_COUNT    = 8;
  localparam int PHASE_ITEMS    = 230;
  localparam int SETTLE_CYCLES  = 10;    // leave margin after the last result
  localparam int WATCHDOG_LIMIT = 2000;

  localparam logic signed [SAMP_W-1:0] SAMP_MIN = 16'sh8000;
  localparam logic signed [SAMP_W-1:0] SAMP_MAX = 16'sh7FFF;

  // Handy coefficient words: re in 31:16, im in 15:0
  localparam logic [COEF_W-1:0] COEF_NEG     = 32'h8000_8000;   // -1 - 1j
  localparam logic [COEF_W-1:0] COEF_POS     = 32'h7FFF_7FFF;
  localparam logic [COEF_W-1:0] COEF_UNIT_RE = 32'h7FFF_0000;
  localparam logic [COEF_W-1:0] COEF_MIX_A   = 32'h7FFF_8000;
  localparam logic [COEF_W-1:0] COEF_MIX_B   = 32'h8000_7FFF;

  typedef enum int {IDLE_NONE, IDLE_LIGHT, IDLE_HEAVY} idle_mode_e;
  typedef enum int {
    CFG_RANDOM, CFG_NEG_FULL, CFG_POS_FULL, CFG_IMPULSE, CFG_SPARSE, CFG_CORNERS
  } coef_set_e;

  logic              clk = 1'b0;
  logic              rst_n;
  logic [31:0]       in_tdata;    // sample_re [15:0], sample_im [31:16]
  logic              in_tuser;    // block_start
  logic              in_tvalid;
  logic              in_tready;
  logic [71:0]       out_tdata;   // out_re [35:0], out_im [71:36]
  logic              out_tvalid;
  logic              out_tready;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  int         fail_count;
  int         pending;
  int         results_checked;
  idle_mode_e idle_mode = IDLE_NONE;
  int         samples_sent = 0;
  int         starts_sent = 0;
  int         coef_sets = 0;
  int         quiet_cycles = 0;

  always #5 clk = ~clk;

  complex_fir_filter #(.NUM_TAPS(TAPS)) DUT (
    .clk, .rst_n,
    .in_tdata, .in_tuser, .in_tvalid, .in_tready,
    .out_tdata, .out_tvalid, .out_tready,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  fir_result_checker #(.NUM_TAPS(TAPS)) u_checker (
    .clk, .rst_n,
    .in_tdata, .in_tuser, .in_tvalid, .in_tready,
    .out_tdata, .out_tvalid, .out_tready,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .fail_count, .pending, .results_checked
  );

  // Gap length for either side: often nothing, else a short random gap, now
  // and then a long hole. IDLE_NONE gives back-to-back transfers.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    case (idle_mode)
      IDLE_NONE:  return 0;
      IDLE_LIGHT: return (roll < 75) ? 0 : (roll < 97) ? $urandom_range(1, 3)
                                                       : $urandom_range(4, 16);
      default:    return (roll < 40) ? 0 : (roll < 90) ? $urandom_range(1, 4)
                                                       : $urandom_range(5, 24);
    endcase
  endfunction

  // Sample part, weighted towards the full-scale corners and zero
  function automatic logic signed [SAMP_W-1:0] pick_part();
    case ($urandom_range(0, 9))
      0:       return SAMP_MIN;
      1:       return SAMP_MAX;
      2:       return '0;
      default: return SAMP_W'($urandom);
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] make_coef(input coef_set_e kind, input int tap,
                                                  input int hot_tap);
    case (kind)
      CFG_NEG_FULL: return COEF_NEG;
      CFG_POS_FULL: return COEF_POS;
      CFG_IMPULSE:  return (tap == hot_tap) ? COEF_UNIT_RE : '0;
      CFG_SPARSE:   return ($urandom_range(0, 2) == 0) ? $urandom : '0;
      CFG_CORNERS: begin
        case ($urandom_range(0, 3))
          0:       return COEF_NEG;
          1:       return COEF_POS;
          2:       return COEF_MIX_A;
          default: return COEF_MIX_B;
        endcase
      end
      default:      return $urandom;
    endcase
  endfunction

  // Result side back-pressure, one update per falling edge
  initial begin
    int hold;
    out_tready = 1'b0;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_tready <= 1'b0;
        hold--;
      end else begin
        out_tready <= 1'b1;
        hold = pick_gap();
      end
    end
  end

  // Ends the run if nothing has moved on any channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                 quiet_cycles, pending);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // One sample transfer. valid is only lowered when a gap is wanted, so a
  // back-to-back stream keeps it high with a single update per edge. During
  // a gap the data lines carry junk.
  task automatic push_sample(input logic signed [SAMP_W-1:0] re,
                             input logic signed [SAMP_W-1:0] im, input logic start);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= $urandom;
      in_tuser  <= 1'($urandom);
      repeat (gap) @(negedge clk);
    end
    in_tdata  <= {im, re};
    in_tuser  <= start;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    samples_sent++;
    if (start) starts_sent++;
  endtask

  // Stop the stream and let every outstanding result come back, so the
  // block is idle before the coefficients are touched.
  task automatic drain_stream();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB setup then access; the register updates at the access edge
  task automatic apb_transfer(input logic is_write, input int idx,
                              input logic [COEF_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= ADDR_W'(idx * TAP_STRIDE);
    pwdata  <= is_write ? value : 32'($urandom);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Writes all taps, then reads them back (the checker compares prdata)
  task automatic load_taps(input coef_set_e kind);
    int hot_tap;
    hot_tap = $urandom_range(0, REG_CNT - 1);
    for (int i = 0; i < REG_CNT; i++)
      apb_transfer(1'b1, i, make_coef(kind, i, hot_tap));
    for (int i = 0; i < REG_CNT; i++)
      apb_transfer(1'b0, i, '0);
    coef_sets++;
  endtask

  // Random traffic in frames: each frame opens with block start, with a
  // stray mid-frame block start now and then.
  task automatic run_frames(input int count);
    int frame_left;
    logic start;
    frame_left = 0;
    for (int i = 0; i < count; i++) begin
      if (frame_left == 0) begin
        frame_left = ($urandom_range(0, 7) == 0) ? $urandom_range(41, 200)
                                                 : $urandom_range(1, 40);
        start = 1'b1;
      end else begin
        start = ($urandom_range(0, 49) == 0);
      end
      frame_left--;
      push_sample(pick_part(), pick_part(), start);
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    in_tvalid = 1'b0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: coefficients still at reset, so every sum must be zero
    push_sample(SAMP_MAX, SAMP_MIN, 1'b1);
    push_sample(SAMP_MIN, SAMP_MAX, 1'b0);
    push_sample(16'sd1, -16'sd1, 1'b0);
    drain_stream();

    // All taps at -1-1j against full-scale negative samples: the line fills
    // up to the largest magnitude the outputs ever see, -1 x -1 exact.
    load_taps(CFG_NEG_FULL);
    push_sample(SAMP_MIN, SAMP_MIN, 1'b1);
    repeat (7) push_sample(SAMP_MIN, SAMP_MIN, 1'b0);
    push_sample(SAMP_MAX, SAMP_MAX, 1'b0);
    push_sample(SAMP_MAX, SAMP_MIN, 1'b0);
    push_sample(SAMP_MIN, SAMP_MAX, 1'b0);
    // block start in mid-stream drops the whole history
    push_sample('0, '0, 1'b1);
    push_sample(16'sd1, '0, 1'b0);
    push_sample('0, 16'sd1, 1'b0);
    drain_stream();

    // Mixed-sign extremes, drawn at random for each tap
    load_taps(CFG_CORNERS);
    push_sample(SAMP_MIN, SAMP_MAX, 1'b1);
    push_sample(SAMP_MAX, SAMP_MIN, 1'b0);
    push_sample(SAMP_MIN, SAMP_MIN, 1'b0);
    push_sample(SAMP_MAX, SAMP_MAX, 1'b1);
    push_sample(SAMP_MIN, '0, 1'b0);
    push_sample('0, SAMP_MIN, 1'b0);
    push_sample(-16'sd1, -16'sd1, 1'b0);
    push_sample(16'sd21845, -16'sd21846, 1'b0);
    drain_stream();

    // Random phases: each loads a coefficient set and an idle pattern in turn
    for (int p = 0; p < PHASE_COUNT; p++) begin
      idle_mode = idle_mode_e'(p % 3);
      load_taps(coef_set_e'(p % 6));
      run_frames(PHASE_ITEMS);
      drain_stream();
    end

    $display("Covered %0d samples (%0d with block start) over %0d tap sets, %0d results checked.",
             samples_sent, starts_sent, coef_sets, results_checked);
    $display("Tap sets included all -1-1j, all near +1+1j, single impulses and random mixes.");
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches seen", fail_count);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== complex_fir_filter.f =====
hw/rtl/cfir_pkg.sv
hw/rtl/cfir_cell.sv
hw/rtl/cfir_sum.sv
hw/rtl/complex_fir_filter.sv
tb/fir_result_checker.sv
tb/tb.sv
